FILE: src/assert_macros.svh
// Assertion macros used by cse_core. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/cse_pkg.sv
`default_nettype none

package cse_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  localparam logic [2:0] R_A = 3'd0;
  localparam logic [2:0] R_F = 3'd1;
  localparam logic [2:0] R_B = 3'd2;
  localparam logic [2:0] R_C = 3'd3;
  localparam logic [2:0] R_D = 3'd4;
  localparam logic [2:0] R_E = 3'd5;
  localparam logic [2:0] R_H = 3'd6;
  localparam logic [2:0] R_L = 3'd7;

  localparam logic [7:0] FLAG_Z     = 8'h80;
  localparam int         FLAG_Z_BIT = 7;
  localparam int         FLAG_C_BIT = 4;

  localparam logic [7:0] OPC_CALL_NZ   = 8'hC4;
  localparam logic [7:0] OPC_CALL_Z    = 8'hCC;
  localparam logic [7:0] OPC_CALL      = 8'hCD;
  localparam logic [7:0] OPC_CALL_NC   = 8'hD4;
  localparam logic [7:0] OPC_CALL_C    = 8'hDC;
  localparam logic [7:0] OPC_RST_MASK  = 8'hC7;
  localparam logic [7:0] RST_VEC_MASK  = 8'h38;
  localparam logic [7:0] PAIR_MASK     = 8'hCF;
  localparam logic [7:0] OPC_PUSH_BC   = 8'hC5;
  localparam logic [7:0] OPC_POP_BC    = 8'hC1;
  localparam logic [7:0] ALU_MASK      = 8'hF8;
  localparam logic [7:0] OPC_OR_B      = 8'hB0;
  localparam logic [7:0] OPC_OR_HL     = 8'hB6;
  localparam logic [7:0] OPC_XOR_B     = 8'hA8;
  localparam logic [7:0] OPC_XOR_HL    = 8'hAE;
  localparam logic [7:0] OPC_OR_IMM    = 8'hF6;
  localparam logic [7:0] OPC_XOR_IMM   = 8'hEE;
  localparam logic [7:0] LD_MASK       = 8'hEF;
  localparam logic [7:0] OPC_LDI_STORE = 8'h22;
  localparam logic [7:0] OPC_LDI_LOAD  = 8'h2A;
  localparam logic [7:0] OPC_DI        = 8'hF3;
  localparam logic [7:0] OPC_EI        = 8'hFB;
  localparam int         LD_DEC_BIT    = 4;

  typedef enum logic [3:0] {
    K_NOP, K_CALL, K_RST, K_PUSH, K_POP,
    K_OR_REG, K_OR_MEM, K_OR_IMM, K_XOR_REG, K_XOR_MEM, K_XOR_IMM,
    K_LD_STORE, K_LD_LOAD, K_DI, K_EI
  } kind_t;

  typedef enum logic [2:0] {
    PLAN_NONE, PLAN_WR1, PLAN_RD1, PLAN_WR2, PLAN_RD2
  } plan_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  opcode;
    logic [7:0]  imm_low;
    logic [7:0]  imm_high;
  } item_t;

  typedef struct packed {
    logic [15:0] prog_counter;
    logic [15:0] stack_pointer;
    logic [7:0]  reg_a;
    logic [7:0]  reg_f;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic        irq_enable;
    logic [7:0]  read_byte;
  } result_t;

  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [7:0]  wdata;
  } mem_req_t;

  function automatic kind_t decode_kind(input logic [7:0] op);
    kind_t k;
    priority if (op == OPC_CALL_NZ || op == OPC_CALL_Z || op == OPC_CALL ||
                 op == OPC_CALL_NC || op == OPC_CALL_C) begin
      k = K_CALL;
    end else if ((op & OPC_RST_MASK) == OPC_RST_MASK) begin
      k = K_RST;
    end else if ((op & PAIR_MASK) == OPC_PUSH_BC) begin
      k = K_PUSH;
    end else if ((op & PAIR_MASK) == OPC_POP_BC) begin
      k = K_POP;
    end else if (op == OPC_OR_HL) begin
      k = K_OR_MEM;
    end else if ((op & ALU_MASK) == OPC_OR_B) begin
      k = K_OR_REG;
    end else if (op == OPC_XOR_HL) begin
      k = K_XOR_MEM;
    end else if ((op & ALU_MASK) == OPC_XOR_B) begin
      k = K_XOR_REG;
    end else if (op == OPC_OR_IMM) begin
      k = K_OR_IMM;
    end else if (op == OPC_XOR_IMM) begin
      k = K_XOR_IMM;
    end else if ((op & LD_MASK) == OPC_LDI_STORE) begin
      k = K_LD_STORE;
    end else if ((op & LD_MASK) == OPC_LDI_LOAD) begin
      k = K_LD_LOAD;
    end else if (op == OPC_DI) begin
      k = K_DI;
    end else if (op == OPC_EI) begin
      k = K_EI;
    end else begin
      k = K_NOP;
    end
    return k;
  endfunction

  // Register operand of OR and XOR; the (HL) code never selects from here.
  function automatic logic [2:0] alu_src_reg(input logic [2:0] sel);
    logic [2:0] r;
    unique case (sel)
      3'd0:    r = R_B;
      3'd1:    r = R_C;
      3'd2:    r = R_D;
      3'd3:    r = R_E;
      3'd4:    r = R_H;
      3'd5:    r = R_L;
      default: r = R_A;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/cse_in_if.sv
`default_nettype none

interface cse_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  opcode;
  logic [7:0]  imm_low;
  logic [7:0]  imm_high;

  modport source (output valid, operation, address, data, opcode, imm_low, imm_high,
                  input ready);
  modport sink (input valid, operation, address, data, opcode, imm_low, imm_high,
                output ready);
endinterface

`default_nettype wire

FILE: src/cse_out_if.sv
`default_nettype none

interface cse_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prog_counter;
  logic [15:0] stack_pointer;
  logic [7:0]  reg_a;
  logic [7:0]  reg_f;
  logic [7:0]  reg_b;
  logic [7:0]  reg_c;
  logic [7:0]  reg_d;
  logic [7:0]  reg_e;
  logic [7:0]  reg_h;
  logic [7:0]  reg_l;
  logic        irq_enable;
  logic [7:0]  read_byte;

  modport source (output valid, prog_counter, stack_pointer, reg_a, reg_f, reg_b, reg_c,
                  reg_d, reg_e, reg_h, reg_l, irq_enable, read_byte, input ready);
  modport sink (input valid, prog_counter, stack_pointer, reg_a, reg_f, reg_b, reg_c,
                reg_d, reg_e, reg_h, reg_l, irq_enable, read_byte, output ready);
endinterface

`default_nettype wire

FILE: src/cse_ram.sv
`default_nettype none

module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

FILE: src/cse_core.sv
`default_nettype none
`include "assert_macros.svh"

module cse_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cse_pkg::item_t    in_item,
  input  wire logic              out_free,
  output logic                   finish,
  output cse_pkg::result_t       res,
  output cse_pkg::mem_req_t      mem_req,
  input  wire logic [7:0]        mem_rdata
);
  import cse_pkg::*;

  logic        cur_valid;
  item_t       cur;
  logic [1:0]  step;
  logic [7:0]  pop_lo;

  logic [15:0] pc;
  logic [15:0] sp;
  logic [7:0]  regs [8];
  logic        ime;

  logic [15:0] pc_next;
  logic [15:0] sp_next;
  logic [7:0]  regs_next [8];
  logic        ime_next;
  logic [7:0]  read_byte;

  kind_t       kind;
  plan_t       plan;
  logic        is_exec;
  logic        call_take;
  logic [1:0]  last_step;
  logic        at_last;
  logic [2:0]  pair_hi;
  logic [2:0]  pair_lo;
  logic [15:0] hl;
  logic [15:0] hl_step;
  logic [15:0] push_val;
  logic [7:0]  alu_op;
  logic [7:0]  a_res;

  assign kind    = decode_kind(cur.opcode);
  assign is_exec = cur.operation == OP_EXEC;
  assign hl      = {regs[R_H], regs[R_L]};
  assign hl_step = cur.opcode[LD_DEC_BIT] ? hl - 16'd1 : hl + 16'd1;
  assign pair_hi = {cur.opcode[5:4] + 2'd1, 1'b0};
  assign pair_lo = {cur.opcode[5:4] + 2'd1, 1'b1};

  always_comb begin
    unique case (cur.opcode)
      OPC_CALL_NZ: call_take = !regs[R_F][FLAG_Z_BIT];
      OPC_CALL_Z:  call_take = regs[R_F][FLAG_Z_BIT];
      OPC_CALL_NC: call_take = !regs[R_F][FLAG_C_BIT];
      OPC_CALL_C:  call_take = regs[R_F][FLAG_C_BIT];
      default:     call_take = 1'b1;
    endcase
  end

  always_comb begin
    plan = PLAN_NONE;
    unique case (cur.operation)
      OP_WRITE: plan = PLAN_WR1;
      OP_READ:  plan = PLAN_RD1;
      OP_EXEC: begin
        unique case (kind)
          K_CALL:                        plan = call_take ? PLAN_WR2 : PLAN_NONE;
          K_RST, K_PUSH:                 plan = PLAN_WR2;
          K_POP:                         plan = PLAN_RD2;
          K_OR_MEM, K_XOR_MEM, K_LD_LOAD: plan = PLAN_RD1;
          K_LD_STORE:                    plan = PLAN_WR1;
          default:                       plan = PLAN_NONE;
        endcase
      end
      default: plan = PLAN_NONE;
    endcase
  end

  always_comb begin
    unique case (plan)
      PLAN_RD1, PLAN_WR2: last_step = 2'd1;
      PLAN_RD2:           last_step = 2'd2;
      default:            last_step = 2'd0;
    endcase
  end

  assign at_last  = step == last_step;
  assign finish   = cur_valid && at_last && out_free;
  assign in_ready = !cur_valid || (at_last && out_free);

  always_comb begin
    unique case (kind)
      K_CALL:  push_val = pc + 16'd3;
      K_RST:   push_val = pc + 16'd1;
      default: push_val = {regs[pair_hi], regs[pair_lo]};
    endcase
  end

  // The address is held on the last step so the registered read data stays put
  // while the result waits for the output stage.
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = hl;
    mem_req.wdata = regs[R_A];
    unique case (plan)
      PLAN_WR1: begin
        mem_req.we = cur_valid;
        if (!is_exec) begin
          mem_req.addr  = cur.address;
          mem_req.wdata = cur.data;
        end
      end
      PLAN_RD1: begin
        if (!is_exec) begin
          mem_req.addr = cur.address;
        end
      end
      PLAN_WR2: begin
        mem_req.we = cur_valid;
        if (step == 2'd0) begin
          mem_req.addr  = sp - 16'd1;
          mem_req.wdata = push_val[15:8];
        end else begin
          mem_req.addr  = sp - 16'd2;
          mem_req.wdata = push_val[7:0];
        end
      end
      PLAN_RD2: begin
        mem_req.addr = (step == 2'd0) ? sp : sp + 16'd1;
      end
      default: begin
        mem_req.we = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (kind)
      K_OR_MEM, K_XOR_MEM: alu_op = mem_rdata;
      K_OR_IMM, K_XOR_IMM: alu_op = cur.imm_low;
      default:             alu_op = regs[alu_src_reg(cur.opcode[2:0])];
    endcase
    unique case (kind)
      K_XOR_REG, K_XOR_MEM, K_XOR_IMM: a_res = regs[R_A] ^ alu_op;
      default:                         a_res = regs[R_A] | alu_op;
    endcase
  end

  always_comb begin
    pc_next   = pc;
    sp_next   = sp;
    regs_next = regs;
    ime_next  = ime;
    read_byte = 8'h00;
    if (cur.operation == OP_READ) begin
      read_byte = mem_rdata;
    end
    if (is_exec) begin
      pc_next = pc + 16'd1;
      unique case (kind)
        K_CALL: begin
          if (call_take) begin
            pc_next = {cur.imm_high, cur.imm_low};
            sp_next = sp - 16'd2;
          end else begin
            pc_next = pc + 16'd3;
          end
        end
        K_RST: begin
          pc_next = {8'h00, cur.opcode & RST_VEC_MASK};
          sp_next = sp - 16'd2;
        end
        K_PUSH: begin
          sp_next = sp - 16'd2;
        end
        K_POP: begin
          sp_next            = sp + 16'd2;
          regs_next[pair_hi] = mem_rdata;
          regs_next[pair_lo] = pop_lo;
        end
        K_OR_REG, K_OR_MEM, K_XOR_REG, K_XOR_MEM: begin
          regs_next[R_A] = a_res;
          regs_next[R_F] = (a_res == 8'h00) ? FLAG_Z : 8'h00;
        end
        K_OR_IMM, K_XOR_IMM: begin
          regs_next[R_A] = a_res;
          regs_next[R_F] = (a_res == 8'h00) ? FLAG_Z : 8'h00;
          pc_next        = pc + 16'd2;
        end
        K_LD_STORE: begin
          regs_next[R_H] = hl_step[15:8];
          regs_next[R_L] = hl_step[7:0];
        end
        K_LD_LOAD: begin
          regs_next[R_A] = mem_rdata;
          regs_next[R_H] = hl_step[15:8];
          regs_next[R_L] = hl_step[7:0];
        end
        K_DI: ime_next = 1'b0;
        K_EI: ime_next = 1'b1;
        default: begin
          pc_next = pc + 16'd1;
        end
      endcase
    end
  end

  always_comb begin
    res.prog_counter  = pc_next;
    res.stack_pointer = sp_next;
    res.reg_a         = regs_next[R_A];
    res.reg_f         = regs_next[R_F];
    res.reg_b         = regs_next[R_B];
    res.reg_c         = regs_next[R_C];
    res.reg_d         = regs_next[R_D];
    res.reg_e         = regs_next[R_E];
    res.reg_h         = regs_next[R_H];
    res.reg_l         = regs_next[R_L];
    res.irq_enable    = ime_next;
    res.read_byte     = read_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= 2'd0;
      pc        <= 16'h0000;
      sp        <= 16'h0000;
      ime       <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        regs[i] <= 8'h00;
      end
    end else begin
      if (in_valid && in_ready) begin
        cur_valid <= 1'b1;
        step      <= 2'd0;
      end else if (finish) begin
        cur_valid <= 1'b0;
        step      <= 2'd0;
      end else if (cur_valid && !at_last) begin
        step <= step + 2'd1;
      end
      if (finish) begin
        pc   <= pc_next;
        sp   <= sp_next;
        regs <= regs_next;
        ime  <= ime_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_item;
    end
    if (cur_valid && plan == PLAN_RD2 && step == 2'd1) begin
      pop_lo <= mem_rdata;
    end
  end

  `ASSERT_IMPLIES(a_step_bound, cur_valid, step <= last_step)
  `ASSERT_IMPLIES(a_read_no_write, cur_valid && (plan == PLAN_RD1 || plan == PLAN_RD2), !mem_req.we)
  `ASSERT_NEXT(a_push_sp, finish && is_exec && plan == PLAN_WR2, sp == $past(sp) - 16'd2)
  `ASSERT_NEXT(a_pop_sp, finish && is_exec && plan == PLAN_RD2, sp == $past(sp) + 16'd2)
  `ASSERT_NEXT(a_mem_op_pc, finish && !is_exec, pc == $past(pc))

endmodule

`default_nettype wire

FILE: src/cse_out.sv
`default_nettype none

module cse_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire cse_pkg::result_t res,
  output logic                  out_free,
  cse_out_if.source             results
);
  import cse_pkg::*;

  logic    valid;
  result_t held;

  assign out_free = !valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (results.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign results.valid         = valid;
  assign results.prog_counter  = held.prog_counter;
  assign results.stack_pointer = held.stack_pointer;
  assign results.reg_a         = held.reg_a;
  assign results.reg_f         = held.reg_f;
  assign results.reg_b         = held.reg_b;
  assign results.reg_c         = held.reg_c;
  assign results.reg_d         = held.reg_d;
  assign results.reg_e         = held.reg_e;
  assign results.reg_h         = held.reg_h;
  assign results.reg_l         = held.reg_l;
  assign results.irq_enable    = held.irq_enable;
  assign results.read_byte     = held.read_byte;

endmodule

`default_nettype wire

FILE: src/cpu_stack_logic_execute.sv
`default_nettype none

// Executes one beat per item against a register file in flip-flops and a byte
// memory of MEM_DEPTH entries (a power of two; addresses wrap modulo the depth).
// A single read (memory read, OR or XOR with (HL), load through HL) waits for
// the registered read data, two-byte stores (PUSH, RST, taken CALL) write
// their bytes in turn and POP reads its bytes in turn, all on the single port
// of the byte memory; an item with no memory access or a single write needs
// one step. A new beat is taken in the cycle the previous item finishes, and
// a finished result waits in an output register. The memory has no reset and
// no clearing pass, so its contents are undefined until written.
module cpu_stack_logic_execute #(
  parameter int MEM_DEPTH = 65536
) (
  input wire logic  clk,
  input wire logic  rst,
  cse_in_if.sink    items,
  cse_out_if.source results
);
  import cse_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);

  item_t    in_item;
  result_t  res;
  mem_req_t mem_req;
  logic     finish;
  logic     out_free;
  logic     in_ready;
  logic [7:0] mem_rdata;

  assign in_item.operation = items.operation;
  assign in_item.address   = items.address;
  assign in_item.data      = items.data;
  assign in_item.opcode    = items.opcode;
  assign in_item.imm_low   = items.imm_low;
  assign in_item.imm_high  = items.imm_high;
  assign items.ready       = in_ready;

  cse_core core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_free  (out_free),
    .finish    (finish),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  cse_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) byte_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr[AW-1:0]),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  cse_out out_stage (
    .clk      (clk),
    .rst      (rst),
    .load     (finish),
    .res      (res),
    .out_free (out_free),
    .results  (results)
  );

endmodule

`default_nettype wire

FILE: sim/tb_cpu_stack_logic_execute.sv
`timescale 1ns / 1ps

module tb_cpu_stack_logic_execute;
  import cse_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [7:0] OPC_NOP      = 8'h00;
  localparam logic [2:0] SEL_HL_MEM   = 3'd6;
  localparam logic [2:0] SEL_A        = 3'd7;
  localparam logic [1:0] PAIR_AF      = 2'd3;
  localparam logic [7:0] PAIR_DE_BITS = 8'h10;
  localparam logic [7:0] PAIR_HL_BITS = 8'h20;
  localparam logic [7:0] PAIR_AF_BITS = 8'h30;
  localparam logic [7:0] LD_DEC_FLAG  = 8'h01 << LD_DEC_BIT;
  localparam int ITEM_COUNT  = 1300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;

  typedef struct {
    item_t   beat;
    result_t want;
    logic    hold;
  } beat_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cse_in_if  items_if ();
  cse_out_if results_if ();

  cpu_stack_logic_execute u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_if),
    .results (results_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow CPU state, advanced as beats are generated in order.
  logic [15:0] pc_q;
  logic [15:0] sp_q;
  logic [7:0]  regs [0:7];
  logic        ime_q;
  logic [7:0]  mem_q [logic [15:0]];
  logic [15:0] written_addrs [$];

  beat_entry_t pending_beats [$];
  result_t     expected_states [$];
  beat_entry_t next_beat;
  result_t     cur_want;
  logic        hold_next = 1'b0;
  logic        steady_in = 1'b0;
  logic        steady_out = 1'b0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] mem_get(input logic [15:0] a);
    return mem_q.exists(a) ? mem_q[a] : 8'h00;
  endfunction

  task automatic mem_put(input logic [15:0] a, input logic [7:0] v);
    if (!mem_q.exists(a)) written_addrs.push_back(a);
    mem_q[a] = v;
  endtask

  task automatic push_word(input logic [15:0] v);
    mem_put(sp_q - 16'd1, v[15:8]);
    mem_put(sp_q - 16'd2, v[7:0]);
    sp_q = sp_q - 16'd2;
  endtask

  task automatic pair_regs(input logic [1:0] p, output logic [2:0] hr, output logic [2:0] lr);
    if (p == PAIR_AF) begin
      hr = R_A;
      lr = R_F;
    end else begin
      hr = R_B + {p, 1'b0};
      lr = R_C + {p, 1'b0};
    end
  endtask

  task automatic exec_instr(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] nxt;
    logic [15:0] hl;
    logic [7:0]  src;
    logic [2:0]  sel;
    logic [2:0]  hr;
    logic [2:0]  lr;
    logic        take;
    nxt = pc_q + 16'd1;
    hl = {regs[R_H], regs[R_L]};
    sel = op[2:0];
    if (op inside {OPC_CALL_NZ, OPC_CALL_Z, OPC_CALL, OPC_CALL_NC, OPC_CALL_C}) begin
      case (op)
        OPC_CALL_NZ: take = !regs[R_F][FLAG_Z_BIT];
        OPC_CALL_Z:  take = regs[R_F][FLAG_Z_BIT];
        OPC_CALL_NC: take = !regs[R_F][FLAG_C_BIT];
        OPC_CALL_C:  take = regs[R_F][FLAG_C_BIT];
        default:     take = 1'b1;
      endcase
      nxt = pc_q + 16'd3;
      if (take) begin
        push_word(nxt);
        nxt = {hi, lo};
      end
    end else if ((op & OPC_RST_MASK) == OPC_RST_MASK) begin
      push_word(nxt);
      nxt = {8'h00, op & RST_VEC_MASK};
    end else if ((op & PAIR_MASK) == OPC_PUSH_BC) begin
      pair_regs(op[5:4], hr, lr);
      push_word({regs[hr], regs[lr]});
    end else if ((op & PAIR_MASK) == OPC_POP_BC) begin
      pair_regs(op[5:4], hr, lr);
      regs[lr] = mem_get(sp_q);
      regs[hr] = mem_get(sp_q + 16'd1);
      sp_q = sp_q + 16'd2;
    end else if ((op & ALU_MASK) == OPC_OR_B || (op & ALU_MASK) == OPC_XOR_B) begin
      if (sel == SEL_HL_MEM) begin
        src = mem_get(hl);
      end else if (sel == SEL_A) begin
        src = regs[R_A];
      end else begin
        src = regs[R_B + sel];
      end
      if ((op & ALU_MASK) == OPC_OR_B) begin
        regs[R_A] = regs[R_A] | src;
      end else begin
        regs[R_A] = regs[R_A] ^ src;
      end
      regs[R_F] = (regs[R_A] == 8'h00) ? FLAG_Z : 8'h00;
    end else if (op == OPC_OR_IMM || op == OPC_XOR_IMM) begin
      regs[R_A] = (op == OPC_OR_IMM) ? (regs[R_A] | lo) : (regs[R_A] ^ lo);
      regs[R_F] = (regs[R_A] == 8'h00) ? FLAG_Z : 8'h00;
      nxt = pc_q + 16'd2;
    end else if ((op & LD_MASK) == OPC_LDI_STORE || (op & LD_MASK) == OPC_LDI_LOAD) begin
      if ((op & LD_MASK) == OPC_LDI_STORE) begin
        mem_put(hl, regs[R_A]);
      end else begin
        regs[R_A] = mem_get(hl);
      end
      hl = op[LD_DEC_BIT] ? hl - 16'd1 : hl + 16'd1;
      {regs[R_H], regs[R_L]} = hl;
    end else if (op == OPC_DI) begin
      ime_q = 1'b0;
    end else if (op == OPC_EI) begin
      ime_q = 1'b1;
    end
    pc_q = nxt;
  endtask

  task automatic run_beat(input item_t it, output result_t res);
    logic [7:0] rd;
    rd = 8'h00;
    case (it.operation)
      OP_WRITE: mem_put(it.address, it.data);
      OP_READ:  rd = mem_get(it.address);
      OP_EXEC:  exec_instr(it.opcode, it.imm_low, it.imm_high);
      default:  ;
    endcase
    res.prog_counter  = pc_q;
    res.stack_pointer = sp_q;
    res.reg_a         = regs[R_A];
    res.reg_f         = regs[R_F];
    res.reg_b         = regs[R_B];
    res.reg_c         = regs[R_C];
    res.reg_d         = regs[R_D];
    res.reg_e         = regs[R_E];
    res.reg_h         = regs[R_H];
    res.reg_l         = regs[R_L];
    res.irq_enable    = ime_q;
    res.read_byte     = rd;
  endtask

  function automatic item_t any_item();
    item_t it;
    it.operation = 2'($urandom_range(0, 3));
    it.address   = 16'($urandom);
    it.data      = 8'($urandom);
    it.opcode    = 8'($urandom);
    it.imm_low   = 8'($urandom);
    it.imm_high  = 8'($urandom);
    return it;
  endfunction

  task automatic enqueue_beat(input item_t it);
    beat_entry_t e;
    result_t     res;
    run_beat(it, res);
    e.beat = it;
    e.want = res;
    e.hold = hold_next;
    hold_next = 1'b0;
    pending_beats.push_back(e);
  endtask

  // Memory that was never written must not be read, so such bytes get a write first.
  task automatic queue_item(input item_t it);
    logic [15:0] need [$];
    item_t       fill;
    if (it.operation == OP_READ) begin
      need.push_back(it.address);
    end else if (it.operation == OP_EXEC) begin
      if ((it.opcode & PAIR_MASK) == OPC_POP_BC) begin
        need.push_back(sp_q);
        need.push_back(sp_q + 16'd1);
      end else if (it.opcode == OPC_OR_HL || it.opcode == OPC_XOR_HL ||
                   (it.opcode & LD_MASK) == OPC_LDI_LOAD) begin
        need.push_back({regs[R_H], regs[R_L]});
      end
    end
    foreach (need[i]) begin
      if (!mem_q.exists(need[i])) begin
        fill = any_item();
        fill.operation = OP_WRITE;
        fill.address = need[i];
        enqueue_beat(fill);
      end
    end
    enqueue_beat(it);
  endtask

  task automatic put_exec(input logic [7:0] op, input logic [7:0] lo = 8'h00,
                          input logic [7:0] hi = 8'h00);
    item_t it;
    it = any_item();
    it.operation = OP_EXEC;
    it.opcode = op;
    it.imm_low = lo;
    it.imm_high = hi;
    queue_item(it);
  endtask

  task automatic put_mem(input logic [1:0] operation, input logic [15:0] a,
                         input logic [7:0] d);
    item_t it;
    it = any_item();
    it.operation = operation;
    it.address = a;
    it.data = d;
    queue_item(it);
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] calls [0:4];
    int r;
    calls = '{OPC_CALL_NZ, OPC_CALL_Z, OPC_CALL, OPC_CALL_NC, OPC_CALL_C};
    r = $urandom_range(0, 99);
    if (r < 14) return calls[$urandom_range(0, 4)];
    if (r < 22) return OPC_RST_MASK | (8'($urandom) & RST_VEC_MASK);
    if (r < 36) return OPC_PUSH_BC | (8'($urandom) & PAIR_AF_BITS);
    if (r < 50) return OPC_POP_BC | (8'($urandom) & PAIR_AF_BITS);
    if (r < 62) return OPC_OR_B | 8'($urandom_range(0, 7));
    if (r < 74) return OPC_XOR_B | 8'($urandom_range(0, 7));
    if (r < 78) return OPC_OR_IMM;
    if (r < 82) return OPC_XOR_IMM;
    if (r < 90) begin
      return ($urandom_range(0, 1) ? OPC_LDI_LOAD : OPC_LDI_STORE) |
             ($urandom_range(0, 1) ? LD_DEC_FLAG : 8'h00);
    end
    if (r < 93) return OPC_DI;
    if (r < 96) return OPC_EI;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic note_field(input string name, input logic [15:0] want,
                            input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on result %0d, %s: expected %h, got %h",
                 results_seen, name, want, got);
      end
    end
  endtask

  task automatic check_result();
    result_t want;
    if (expected_states.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result %0d arrived with nothing expected", results_seen);
    end else begin
      want = expected_states.pop_front();
      note_field("prog_counter", want.prog_counter, results_if.prog_counter);
      note_field("stack_pointer", want.stack_pointer, results_if.stack_pointer);
      note_field("reg_a", 16'(want.reg_a), 16'(results_if.reg_a));
      note_field("reg_f", 16'(want.reg_f), 16'(results_if.reg_f));
      note_field("reg_b", 16'(want.reg_b), 16'(results_if.reg_b));
      note_field("reg_c", 16'(want.reg_c), 16'(results_if.reg_c));
      note_field("reg_d", 16'(want.reg_d), 16'(results_if.reg_d));
      note_field("reg_e", 16'(want.reg_e), 16'(results_if.reg_e));
      note_field("reg_h", 16'(want.reg_h), 16'(results_if.reg_h));
      note_field("reg_l", 16'(want.reg_l), 16'(results_if.reg_l));
      note_field("irq_enable", 16'(want.irq_enable), 16'(results_if.irq_enable));
      note_field("read_byte", 16'(want.read_byte), 16'(results_if.read_byte));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (items_if.valid && items_if.ready) begin
        expected_states.push_back(cur_want);
        in_gap = steady_in ? 0 : pick_gap();
        if ($urandom_range(0, 99) == 0) steady_in = !steady_in;
      end
      if (!items_if.valid || items_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          items_if.valid <= 1'b0;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].hold && expected_states.size() != 0)) begin
          next_beat = pending_beats.pop_front();
          cur_want = next_beat.want;
          items_if.operation <= next_beat.beat.operation;
          items_if.address   <= next_beat.beat.address;
          items_if.data      <= next_beat.beat.data;
          items_if.opcode    <= next_beat.beat.opcode;
          items_if.imm_low   <= next_beat.beat.imm_low;
          items_if.imm_high  <= next_beat.beat.imm_high;
          items_if.valid     <= 1'b1;
        end else begin
          items_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (results_if.valid && results_if.ready) check_result();
      if (out_stall > 0) begin
        out_stall--;
        results_if.ready <= 1'b0;
      end else if (!steady_out && $urandom_range(0, 99) < 30) begin
        out_stall = pick_gap();
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= 1'b1;
      end
      if ($urandom_range(0, 199) == 0) steady_out = !steady_out;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    item_t it;
    int    r;
    items_if.valid = 1'b0;
    items_if.operation = OP_WRITE;
    items_if.address = 16'h0000;
    items_if.data = 8'h00;
    items_if.opcode = OPC_NOP;
    items_if.imm_low = 8'h00;
    items_if.imm_high = 8'h00;
    results_if.ready = 1'b0;
    pc_q = 16'h0000;
    sp_q = 16'h0000;
    ime_q = 1'b0;
    foreach (regs[i]) regs[i] = 8'h00;

    put_mem(OP_WRITE, 16'hFFFF, 8'h00);
    put_mem(OP_READ, 16'hFFFF, 8'hFF);
    put_exec(OPC_EI);
    put_exec(OPC_XOR_B | 8'(SEL_A));
    put_exec(OPC_CALL_NZ, 8'h34, 8'h12);
    put_exec(OPC_CALL_Z, 8'hFE, 8'hFF);
    put_exec(OPC_OR_IMM, 8'hFF);
    put_exec(OPC_CALL_NZ, 8'hFF, 8'h00);
    put_exec(OPC_RST_MASK | RST_VEC_MASK);
    put_exec(OPC_RST_MASK);
    put_exec(OPC_PUSH_BC | PAIR_AF_BITS);
    put_mem(OP_WRITE, sp_q, 8'hFF);
    put_exec(OPC_POP_BC | PAIR_AF_BITS);
    put_exec(OPC_CALL_C, 8'h00, 8'h01);
    put_exec(OPC_XOR_IMM, 8'h5A);
    put_exec(OPC_CALL_Z, 8'h11, 8'h22);
    put_exec(OPC_CALL_C, 8'h33, 8'h44);
    put_exec(OPC_CALL_NC, 8'h00, 8'h80);
    put_exec(OPC_CALL, 8'h00, 8'h40);
    put_mem(OP_WRITE, sp_q, 8'hFF);
    put_mem(OP_WRITE, sp_q + 16'd1, 8'hFF);
    put_exec(OPC_POP_BC | PAIR_HL_BITS);
    hold_next = 1'b1;
    put_exec(OPC_LDI_STORE);
    put_exec(OPC_LDI_LOAD | LD_DEC_FLAG);
    put_exec(OPC_LDI_LOAD);
    put_exec(OPC_LDI_STORE | LD_DEC_FLAG);
    put_exec(OPC_POP_BC | PAIR_DE_BITS);
    put_exec(OPC_OR_B);
    put_exec(OPC_OR_HL);
    put_exec(OPC_XOR_HL);
    put_exec(OPC_DI);
    put_exec(OPC_NOP);
    put_mem(OP_UNUSED, 16'h0000, 8'h00);

    for (int n = 0; n < ITEM_COUNT; n++) begin
      if (n == ITEM_COUNT / 2) hold_next = 1'b1;
      it = any_item();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        it.operation = OP_WRITE;
        if ($urandom_range(0, 1)) it.address = sp_q + 16'($urandom_range(0, 7));
      end else if (r < 15) begin
        it.operation = OP_READ;
        if ($urandom_range(0, 9) < 6) begin
          it.address = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
        end
      end else if (r < 17) begin
        it.operation = OP_UNUSED;
      end else begin
        it.operation = OP_EXEC;
        it.opcode = pick_opcode();
      end
      queue_item(it);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0 || items_if.valid || expected_states.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
